### rtl/seglcd_pkg.sv
package seglcd_pkg;

  localparam int COM_LINES   = 4;
  localparam int SEG_LINES   = 12;
  localparam int COM_IDX_W   = 2;
  localparam int PHASE_W     = 3;
  localparam int CHAR_W      = 4;
  localparam int POS_W       = 3;
  localparam int GLYPH_W     = 8;
  localparam int IN_DATA_W   = 8;
  localparam int OUT_DATA_W  = 24;

  // Last legal glyph index (ampersand) and last legal digit position
  localparam logic [CHAR_W-1:0] CHAR_MAX = 4'd10;
  localparam logic [POS_W-1:0]  POS_MAX  = 3'd5;

  typedef enum logic {
    CMD_TICK  = 1'b0,
    CMD_WRITE = 1'b1
  } cmd_t;

  typedef logic [SEG_LINES-1:0] seg_row_t;

  // Low nibble drives the even segment, high nibble the odd one, bit k = COM row k
  function automatic logic [GLYPH_W-1:0] glyph(input logic [CHAR_W-1:0] ch);
    logic [GLYPH_W-1:0] g;
    case (ch)
      4'd0:    g = 8'h5F;
      4'd1:    g = 8'h06;
      4'd2:    g = 8'h6B;
      4'd3:    g = 8'h2F;
      4'd4:    g = 8'h36;
      4'd5:    g = 8'h3D;
      4'd6:    g = 8'h7A;
      4'd7:    g = 8'h07;
      4'd8:    g = 8'h7F;
      4'd9:    g = 8'h7F;
      4'd10:   g = 8'h80;
      default: g = 8'h00;
    endcase
    return g;
  endfunction

endpackage

### rtl/segment_lcd_mux_driver_top.sv
// Multiplexed segment LCD driver for four COM lines and twelve segment lines at 1/4 duty.
// Each input word is either a refresh tick (tuser = 0) that advances the eight-phase
// drive cycle, or a glyph write (tuser = 1) that stores a digit 0-9 or an ampersand
// (index 10) at position 0-5 into the segment table. Every input word gives one output
// word holding the COM drive enables, COM levels and segment levels after that word,
// plus a reject flag set for a write with a bad character or position. After a write
// the pins are unchanged; new table contents appear at the next even phase. One word is
// taken per clock unless the output side stalls: the update is a single table row select
// into a result register, which holds while stalled. The table is blank after reset.
module segment_lcd_mux_driver_top (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [3:0] character, [6:4] position, [7] zero
  input  logic        s_tuser,   // [0] command
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [23:0] m_tdata    // [3:0] com_driven, [7:4] com_level,
                                 // [19:8] segment_lines, [20] rejected, [23:21] zero
);

  logic [seglcd_pkg::PHASE_W-1:0]   phase, phase_next;
  seglcd_pkg::seg_row_t             seg_table [seglcd_pkg::COM_LINES];
  seglcd_pkg::seg_row_t             seg_table_next [seglcd_pkg::COM_LINES];
  logic [seglcd_pkg::COM_LINES-1:0] com_drive, com_drive_next;
  logic [seglcd_pkg::COM_LINES-1:0] com_level, com_level_next;
  seglcd_pkg::seg_row_t             seg_out, seg_out_next;
  logic                             rejected, rejected_next;

  logic                             accept;
  seglcd_pkg::cmd_t                 cmd;
  logic [seglcd_pkg::CHAR_W-1:0]    character;
  logic [seglcd_pkg::POS_W-1:0]     position;
  logic [seglcd_pkg::COM_IDX_W-1:0] com_k, com_prev;
  logic [seglcd_pkg::GLYPH_W-1:0]   glyph_bits;
  logic [3:0]                       low_seg;

  assign s_tready  = !m_tvalid || m_tready;
  assign accept    = s_tvalid && s_tready;
  assign cmd       = seglcd_pkg::cmd_t'(s_tuser);
  assign character = s_tdata[3:0];
  assign position  = s_tdata[6:4];
  assign com_k     = phase[seglcd_pkg::PHASE_W-1:1];
  assign com_prev  = com_k - 1'b1;
  assign glyph_bits = seglcd_pkg::glyph(character);
  assign low_seg   = {position, 1'b0};

  always_comb begin
    phase_next     = phase;
    seg_table_next = seg_table;
    com_drive_next = com_drive;
    com_level_next = com_level;
    seg_out_next   = seg_out;
    rejected_next  = 1'b0;
    case (cmd)
      seglcd_pkg::CMD_TICK: begin
        if (!phase[0]) begin
          // float and raise the previous COM, pull COM k low, load row k
          com_drive_next[com_prev] = 1'b0;
          com_level_next[com_prev] = 1'b1;
          com_level_next[com_k]    = 1'b0;
          com_drive_next[com_k]    = 1'b1;
          seg_out_next             = seg_table[com_k];
        end else begin
          com_level_next[com_k] = 1'b1;
          seg_out_next          = ~seg_out;
        end
        phase_next = phase + 1'b1;
      end
      seglcd_pkg::CMD_WRITE: begin
        if (character > seglcd_pkg::CHAR_MAX || position > seglcd_pkg::POS_MAX) begin
          rejected_next = 1'b1;
        end else begin
          for (int r = 0; r < seglcd_pkg::COM_LINES; r++) begin
            seg_table_next[r][low_seg +: 2] = {glyph_bits[r+4], glyph_bits[r]};
          end
        end
      end
      default: begin
        rejected_next = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase     <= '0;
      com_drive <= '0;
      com_level <= '1;
      seg_out   <= '0;
      rejected  <= 1'b0;
      m_tvalid  <= 1'b0;
      for (int r = 0; r < seglcd_pkg::COM_LINES; r++) begin
        seg_table[r] <= '0;
      end
    end else begin
      if (accept) begin
        phase     <= phase_next;
        seg_table <= seg_table_next;
        com_drive <= com_drive_next;
        com_level <= com_level_next;
        seg_out   <= seg_out_next;
        rejected  <= rejected_next;
        m_tvalid  <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  assign m_tdata = {3'b000, rejected, seg_out, com_level, com_drive};

endmodule

### rtl/seglcd_checker.sv
module seglcd_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_tvalid,
  input logic        s_tready,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [23:0] m_tdata
);

  // a stalled output word holds
  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("output word changed while stalled");

  // no word may appear without an accepted input word
  a_no_invent: assert property (@(posedge clk) disable iff (rst)
    !m_tvalid && !(s_tvalid && s_tready) |=> !m_tvalid)
    else $error("output word without input word");

  // at most one COM line is ever driven
  a_one_com: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> $onehot0(m_tdata[seglcd_pkg::COM_LINES-1:0]))
    else $error("more than one COM driven");

  // a floating COM line always sits at the high level
  a_float_high: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> ((~m_tdata[3:0] & ~m_tdata[7:4]) == 4'b0000))
    else $error("floating COM line not high");

endmodule

bind segment_lcd_mux_driver_top seglcd_checker u_seglcd_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);
